FILE: sv/nmd_pkg.sv
// shared types, constants and helper functions of the message decoder
package nmd_pkg;

  localparam int CHAR_W = 8;
  localparam int VALUE_W = 16;
  localparam int NUM_TYPES = 5;
  localparam int NAME_LEN = 3;
  localparam logic [7:0] PAYLOAD_MAX = 8'd128;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_CR = 8'd13;

  // event kinds
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_ERROR = 3'd1;
  localparam logic [2:0] EV_CHA = 3'd2;

  // error codes
  localparam logic [2:0] ERR_DELIM = 3'd0;
  localparam logic [2:0] ERR_PAYLOAD_LONG = 3'd1;
  localparam logic [2:0] ERR_CHECK_LONG = 3'd2;
  localparam logic [2:0] ERR_CHECK_SHORT = 3'd3;
  localparam logic [2:0] ERR_PARSE = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX = 3'd5;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_CHECK   = 3'b100
  } phase_t;

  typedef enum logic [4:0] {
    NS_BETWEEN = 5'b00001,
    NS_LEAD    = 5'b00010,
    NS_POS     = 5'b00100,
    NS_NEG     = 5'b01000,
    NS_SKIP    = 5'b10000
  } num_state_t;

  // one classified character as it travels from front to back
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic is_dollar;
    logic is_star;
    logic is_newline;
    logic is_comma;
    logic is_ws;
    logic is_plus;
    logic is_minus;
    logic is_digit;
    logic is_hex;
    logic [3:0] nib;
    logic [NAME_LEN-1:0][NUM_TYPES-1:0] name_hit;
  } char_class_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [2:0] error_code;
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;
    logic [VALUE_W-1:0] value_c;
  } event_t;

  // letter at position pos of message type k
  function automatic logic [7:0] type_letter(input logic [2:0] k, input logic [1:0] pos);
    logic [23:0] name;
    case (k)
      3'd0:    name = "CHA";
      3'd1:    name = "ACC";
      3'd2:    name = "SHO";
      3'd3:    name = "REV";
      default: name = "RES";
    endcase
    case (pos)
      2'd0:    type_letter = name[23:16];
      2'd1:    type_letter = name[15:8];
      default: type_letter = name[7:0];
    endcase
  endfunction

  // number of numeric fields that message type k carries
  function automatic logic [2:0] type_args(input logic [2:0] k);
    case (k)
      3'd2:    type_args = 3'd2;
      3'd4:    type_args = 3'd3;
      default: type_args = 3'd1;
    endcase
  endfunction

endpackage

FILE: sv/nmd_char_if.sv
// character channel: valid/ready with one received byte
interface nmd_char_if;
  logic valid;
  logic ready;
  logic [nmd_pkg::CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

FILE: sv/nmd_event_if.sv
// event channel: valid/ready with one decode event
interface nmd_event_if;
  logic valid;
  logic ready;
  logic [2:0] event_kind;
  logic [2:0] error_code;
  logic [nmd_pkg::VALUE_W-1:0] value_a;
  logic [nmd_pkg::VALUE_W-1:0] value_b;
  logic [nmd_pkg::VALUE_W-1:0] value_c;

  modport source (output valid, output event_kind, output error_code,
                  output value_a, output value_b, output value_c, input ready);
  modport sink (input valid, input event_kind, input error_code,
                input value_a, input value_b, input value_c, output ready);
endinterface

FILE: sv/nmd_front.sv
// front end: takes characters and classifies them for the back end
module nmd_front (
  nmd_char_if.sink              rx,
  output logic                  push_valid,
  input  logic                  push_ready,
  output nmd_pkg::char_class_t  push_data
);
  import nmd_pkg::*;

  logic [7:0] c;

  assign c = rx.char_in;
  assign rx.ready = push_ready;
  assign push_valid = rx.valid;

  always_comb begin
    push_data = '0;
    push_data.ch = c;
    push_data.is_dollar = (c == CH_DOLLAR);
    push_data.is_star = (c == CH_STAR);
    push_data.is_newline = (c == CH_NEWLINE);
    push_data.is_comma = (c == CH_COMMA);
    push_data.is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    push_data.is_plus = (c == CH_PLUS);
    push_data.is_minus = (c == CH_MINUS);
    push_data.is_digit = (c >= CH_ZERO && c <= CH_NINE);
    push_data.is_hex = push_data.is_digit || (c >= CH_UPPER_A && c <= CH_UPPER_F);
    // digit value for '0'-'9', letter value for 'A'-'F'
    push_data.nib = push_data.is_digit ? 4'(c - CH_ZERO) : 4'(c - 8'd55);
    for (int p = 0; p < NAME_LEN; p++) begin
      for (int k = 0; k < NUM_TYPES; k++) begin
        push_data.name_hit[p][k] = (type_letter(3'(k), 2'(p)) == c);
      end
    end
  end

endmodule

FILE: sv/nmd_queue.sv
// two-entry queue between the classifier and the decoder
module nmd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  nmd_pkg::char_class_t  push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output nmd_pkg::char_class_t  pop_data
);
  import nmd_pkg::*;

  char_class_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data = entry[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/nmd_back.sv
// back end: framing, checksum and field parsing, one event per character
module nmd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  nmd_pkg::char_class_t  pop_data,
  nmd_event_if.source           evt
);
  import nmd_pkg::*;

  phase_t                   phase, phase_next;
  logic [7:0]               char_count, char_count_next;
  logic [7:0]               running_xor, running_xor_next;
  logic [7:0]               hex_value, hex_value_next;
  logic [2:0]               token_number, token_number_next;
  logic [4:0]               type_mask, type_mask_next;
  logic [2:0]               type_len, type_len_next;
  num_state_t               num_state, num_state_next;
  logic [2:0][VALUE_W-1:0]  field_values, field_values_next;
  logic                     out_valid;
  event_t                   out_event, event_next;
  logic                     fire;

  // parse temporaries
  logic [1:0]               idx;
  logic [VALUE_W-1:0]       v;
  logic [VALUE_W-1:0]       v10;
  logic [2:0]               k;
  logic                     ok;
  char_class_t              e;

  assign e = pop_data;
  assign fire = pop_valid && (!out_valid || evt.ready);
  assign pop_ready = fire;

  assign evt.valid = out_valid;
  assign evt.event_kind = out_event.event_kind;
  assign evt.error_code = out_event.error_code;
  assign evt.value_a = out_event.value_a;
  assign evt.value_b = out_event.value_b;
  assign evt.value_c = out_event.value_c;

  always_comb begin
    phase_next = phase;
    char_count_next = char_count;
    running_xor_next = running_xor;
    hex_value_next = hex_value;
    token_number_next = token_number;
    type_mask_next = type_mask;
    type_len_next = type_len;
    num_state_next = num_state;
    field_values_next = field_values;
    event_next = '0;
    idx = 2'd0;
    v = '0;
    v10 = '0;
    k = 3'd4;
    ok = 1'b0;

    case (phase)
      PH_PAYLOAD: begin
        if (char_count > PAYLOAD_MAX) begin
          phase_next = PH_WAIT;
          char_count_next = 8'd0;
          event_next.event_kind = EV_ERROR;
          event_next.error_code = ERR_PAYLOAD_LONG;
        end else if (e.is_newline || e.is_dollar) begin
          phase_next = PH_WAIT;
          char_count_next = 8'd0;
          event_next.event_kind = EV_ERROR;
          event_next.error_code = ERR_DELIM;
        end else if (e.is_star) begin
          phase_next = PH_CHECK;
          char_count_next = 8'd0;
          hex_value_next = 8'd0;
        end else begin
          running_xor_next = running_xor ^ e.ch;
          char_count_next = char_count + 8'd1;
          if (e.is_comma) begin
            num_state_next = NS_BETWEEN;
          end else begin
            // a new token starts
            if (num_state == NS_BETWEEN) begin
              if (token_number != 3'd7) begin
                token_number_next = token_number + 3'd1;
              end
              if (token_number_next == 3'd1) begin
                type_mask_next = 5'h1F;
                type_len_next = 3'd0;
                num_state_next = NS_SKIP;
              end else if (token_number_next <= 3'd4) begin
                field_values_next[2'(token_number_next - 3'd2)] = '0;
                num_state_next = NS_LEAD;
              end else begin
                num_state_next = NS_SKIP;
              end
            end
            if (token_number_next == 3'd1) begin
              if (type_len_next < 3'd3) begin
                type_mask_next = type_mask_next & e.name_hit[type_len_next[1:0]];
                type_len_next = type_len_next + 3'd1;
              end else begin
                type_len_next = 3'd4;
              end
            end else if (token_number_next >= 3'd2 && token_number_next <= 3'd4 &&
                         (num_state_next == NS_LEAD || num_state_next == NS_POS ||
                          num_state_next == NS_NEG)) begin
              idx = 2'(token_number_next - 3'd2);
              v = field_values_next[idx];
              v10 = {v[12:0], 3'b000} + {v[14:0], 1'b0};
              if (num_state_next == NS_LEAD) begin
                if (e.is_ws) begin
                  num_state_next = NS_LEAD;
                end else if (e.is_plus) begin
                  num_state_next = NS_POS;
                end else if (e.is_minus) begin
                  num_state_next = NS_NEG;
                end else if (e.is_digit) begin
                  field_values_next[idx] = {12'd0, e.nib};
                  num_state_next = NS_POS;
                end else begin
                  num_state_next = NS_SKIP;
                end
              end else if (e.is_digit) begin
                if (num_state_next == NS_POS) begin
                  field_values_next[idx] = v10 + {12'd0, e.nib};
                end else begin
                  field_values_next[idx] = v10 - {12'd0, e.nib};
                end
              end else begin
                num_state_next = NS_SKIP;
              end
            end
          end
        end
      end

      PH_CHECK: begin
        if (char_count > 8'd2) begin
          phase_next = PH_WAIT;
          char_count_next = 8'd0;
          event_next.event_kind = EV_ERROR;
          event_next.error_code = ERR_CHECK_LONG;
        end else if (e.is_newline) begin
          phase_next = PH_WAIT;
          char_count_next = 8'd0;
          if (char_count < 8'd2) begin
            event_next.event_kind = EV_ERROR;
            event_next.error_code = ERR_CHECK_SHORT;
          end else begin
            // first candidate type left in the mask
            if (type_mask[0]) begin
              k = 3'd0;
            end else if (type_mask[1]) begin
              k = 3'd1;
            end else if (type_mask[2]) begin
              k = 3'd2;
            end else if (type_mask[3]) begin
              k = 3'd3;
            end else begin
              k = 3'd4;
            end
            ok = (hex_value == running_xor) && (token_number != 3'd0) &&
                 (type_len == 3'd3) && (type_mask != 5'd0) &&
                 (token_number == 3'd1 + type_args(k));
            if (ok) begin
              event_next.event_kind = EV_CHA + k;
              event_next.value_a = field_values[0];
              event_next.value_b = field_values[1];
              event_next.value_c = field_values[2];
            end else begin
              event_next.event_kind = EV_ERROR;
              event_next.error_code = ERR_PARSE;
            end
          end
        end else if (!e.is_hex) begin
          phase_next = PH_WAIT;
          char_count_next = 8'd0;
          event_next.event_kind = EV_ERROR;
          event_next.error_code = ERR_BAD_HEX;
        end else begin
          hex_value_next = {hex_value[3:0], e.nib};
          char_count_next = char_count + 8'd1;
        end
      end

      default: begin
        if (e.is_dollar) begin
          phase_next = PH_PAYLOAD;
          char_count_next = 8'd0;
          running_xor_next = 8'd0;
          hex_value_next = 8'd0;
          token_number_next = 3'd0;
          type_mask_next = 5'd0;
          type_len_next = 3'd0;
          num_state_next = NS_BETWEEN;
          field_values_next = '0;
        end else begin
          phase_next = PH_WAIT;
          char_count_next = 8'd0;
          event_next.event_kind = EV_ERROR;
          event_next.error_code = ERR_DELIM;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      char_count <= 8'd0;
      running_xor <= 8'd0;
      hex_value <= 8'd0;
      token_number <= 3'd0;
      type_mask <= 5'd0;
      type_len <= 3'd0;
      num_state <= NS_BETWEEN;
      field_values <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase <= phase_next;
        char_count <= char_count_next;
        running_xor <= running_xor_next;
        hex_value <= hex_value_next;
        token_number <= token_number_next;
        type_mask <= type_mask_next;
        type_len <= type_len_next;
        num_state <= num_state_next;
        field_values <= field_values_next;
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_event <= event_next;
    end
  end

endmodule

FILE: sv/nmea_style_message_decoder.sv
// top level of the message decoder: classifier, queue and decoder
//
//   port  | dir | payload                                         | meaning
//   rx    | in  | char_in[7:0]                                    | one received byte
//   evt   | out | event_kind, error_code, value_a/b/c[15:0]       | one event per byte
//
// one character per cycle sustained while evt is ready; the decoder updates all parse state
// per byte; each byte is registered in the queue and then in the output register
// rst is synchronous and clears phase, counters, queue pointers and the output valid
// while evt is stalled the two-entry queue holds up to two bytes, then rx.ready drops
module nmea_style_message_decoder (
  input logic         clk,
  input logic         rst,
  nmd_char_if.sink    rx,
  nmd_event_if.source evt
);
  import nmd_pkg::*;

  logic        push_valid;
  logic        push_ready;
  char_class_t push_data;
  logic        pop_valid;
  logic        pop_ready;
  char_class_t pop_data;

  nmd_front u_front (
    .rx         (rx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  nmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .evt       (evt)
  );

endmodule
